### rtl/imufp_pkg.sv
package imufp_pkg;

    localparam int BYTE_W     = 8;
    localparam int ANGLE_FS_W = 9;
    localparam int RATE_FS_W  = 12;
    localparam int CFG_DATA_W = 12;
    localparam int RAW_W      = 16;
    localparam int YAW_W      = 25;
    localparam int RATE_W     = 28;
    localparam int POS_W      = 4;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;
    localparam logic [7:0] TYPE_RATE  = 8'h52;

    // positions of the first data byte and of the checksum byte within a frame
    localparam logic [POS_W-1:0] POS_FIRST_DATA = 4'd2;
    localparam logic [POS_W-1:0] POS_CSUM       = 4'd10;

    // configuration register indexes
    localparam logic REG_ANGLE_FS = 1'b0;
    localparam logic REG_RATE_FS  = 1'b1;

    localparam logic [ANGLE_FS_W-1:0] ANGLE_FS_RESET = 9'd180;
    localparam logic [RATE_FS_W-1:0]  RATE_FS_RESET  = 12'd2000;

    localparam logic KIND_ANGLE = 1'b0;
    localparam logic KIND_RATE  = 1'b1;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_TYPE,
        ST_BODY
    } parse_state_t;

    // one checked frame, handed from parser to scaler
    typedef struct packed {
        logic             kind;
        logic [BYTE_W-1:0] b7;
        logic [BYTE_W-1:0] b6;
        logic [BYTE_W-1:0] b5;
        logic [BYTE_W-1:0] b4;
    } frame_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### rtl/imu_frame_parser_checksum.sv
// IMU serial frame parser with 8-bit sum checksum.
//
// Input channel (in_valid/in_ready/rx_byte): one received byte per item. The
// parser hunts for header 0x55, then takes type 0x53 (angle) or 0x52 (rate),
// and collects an 11-byte frame; the last byte must match the 8-bit sum of
// the ten before it, else the frame is dropped with no result.
// Output channel (out_valid/out_ready/...): one item per good frame, carrying
// the frame kind and all three held values (yaw, rate y, rate z) with 15
// fractional bits; values a frame did not touch keep their last value.
// Config port (cfg_we/cfg_index/cfg_data): index 0 angle full scale, index 1
// rate full scale; write only while the block is idle.
// Throughput: one byte per cycle while the frame queue has room. The parser
// is a single byte-wide state step with a running sum; scaling is one pass
// through three multipliers (16x9 for the angle, two 16x12 for the rates).
// The edge that accepts the checksum byte writes the frame into the queue;
// the frame is then multiplied into the output register, raising out_valid,
// once that register is free and no older frame waits ahead of it.
// A stalled receiver holds the output register; the parser keeps taking bytes
// until the frame queue (FIFO_DEPTH entries) fills, then drops in_ready.
// Reset: hunting for a header, held values 0, full scales 180 and 2000.
module imu_frame_parser_checksum #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           rx_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 frame_kind,
    output logic signed [imufp_pkg::YAW_W-1:0]   yaw_angle,
    output logic signed [imufp_pkg::RATE_W-1:0]  rate_y,
    output logic signed [imufp_pkg::RATE_W-1:0]  rate_z,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [imufp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [imufp_pkg::ANGLE_FS_W-1:0] angle_fs_reg;
    logic [imufp_pkg::RATE_FS_W-1:0]  rate_fs_reg;

    imufp_pkg::frame_cmd_t front_cmd, back_cmd;
    imufp_pkg::q_status_t  q_stat;
    logic q_push;
    logic q_pop;

    // full-scale registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_fs_reg <= imufp_pkg::ANGLE_FS_RESET;
            rate_fs_reg  <= imufp_pkg::RATE_FS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                imufp_pkg::REG_ANGLE_FS: angle_fs_reg <= cfg_data[imufp_pkg::ANGLE_FS_W-1:0];
                imufp_pkg::REG_RATE_FS:  rate_fs_reg  <= cfg_data[imufp_pkg::RATE_FS_W-1:0];
                default: ;
            endcase
        end
    end

    // byte parser and checksum
    imufp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .q_stat   (q_stat),
        .push     (q_push),
        .cmd      (front_cmd)
    );

    // checked frames waiting for the scaler
    imufp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (front_cmd),
        .pop     (q_pop),
        .rd_data (back_cmd),
        .stat    (q_stat)
    );

    // scaling and result register
    imufp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (!q_stat.empty),
        .cmd        (back_cmd),
        .pop        (q_pop),
        .angle_fs   (angle_fs_reg),
        .rate_fs    (rate_fs_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_kind (frame_kind),
        .yaw_angle  (yaw_angle),
        .rate_y     (rate_y),
        .rate_z     (rate_z)
    );

`ifndef SYNTH
    a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("frame pushed into full queue");

    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!q_stat.empty && (!out_valid || out_ready)))
        else $error("frame popped with no room in output register");

    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid)
        else $error("popped frame did not reach the output");
`endif

endmodule

### rtl/imufp_front.sv
module imufp_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               rx_byte,
    input  imufp_pkg::q_status_t     q_stat,
    output logic                     push,
    output imufp_pkg::frame_cmd_t    cmd
);

    imufp_pkg::parse_state_t state_reg, state_next;
    logic [imufp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0] sum_reg, sum_next;
    logic       kind_reg, kind_next;
    logic [7:0] payload_reg [4];
    logic       accept;
    logic       is_type;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign is_type  = (rx_byte == imufp_pkg::TYPE_ANGLE) || (rx_byte == imufp_pkg::TYPE_RATE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        kind_next  = kind_reg;
        if (accept)
        begin
            case (state_reg)
                imufp_pkg::ST_HUNT:
                begin
                    if (rx_byte == imufp_pkg::HDR_BYTE)
                    begin
                        state_next = imufp_pkg::ST_TYPE;
                        sum_next   = imufp_pkg::HDR_BYTE;
                    end
                end
                imufp_pkg::ST_TYPE:
                begin
                    if (is_type)
                    begin
                        state_next = imufp_pkg::ST_BODY;
                        sum_next   = sum_reg + rx_byte;
                        pos_next   = imufp_pkg::POS_FIRST_DATA;
                        kind_next  = (rx_byte == imufp_pkg::TYPE_ANGLE) ?
                                     imufp_pkg::KIND_ANGLE : imufp_pkg::KIND_RATE;
                    end
                    else if (rx_byte == imufp_pkg::HDR_BYTE)
                    begin
                        sum_next = imufp_pkg::HDR_BYTE;
                    end
                    else
                    begin
                        state_next = imufp_pkg::ST_HUNT;
                    end
                end
                imufp_pkg::ST_BODY:
                begin
                    if (pos_reg == imufp_pkg::POS_CSUM)
                    begin
                        state_next = imufp_pkg::ST_HUNT;
                    end
                    else
                    begin
                        sum_next = sum_reg + rx_byte;
                        pos_next = pos_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_next = imufp_pkg::ST_HUNT;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        push = 1'b0;
        case (state_reg)
            imufp_pkg::ST_BODY:
                push = accept && (pos_reg == imufp_pkg::POS_CSUM) && (rx_byte == sum_reg);
            default:
                push = 1'b0;
        endcase
    end

    assign cmd.kind = kind_reg;
    assign cmd.b4   = payload_reg[0];
    assign cmd.b5   = payload_reg[1];
    assign cmd.b6   = payload_reg[2];
    assign cmd.b7   = payload_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imufp_pkg::ST_HUNT;
            pos_reg   <= '0;
            sum_reg   <= '0;
            kind_reg  <= imufp_pkg::KIND_ANGLE;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            kind_reg  <= kind_next;
        end
    end

    // frame bytes 4..7; position bits [1:0] pick the slot
    always_ff @(posedge clk)
    begin
        if (accept && (state_reg == imufp_pkg::ST_BODY) && (pos_reg[3:2] == 2'b01))
        begin
            payload_reg[pos_reg[1:0]] <= rx_byte;
        end
    end

endmodule

### rtl/imufp_fifo.sv
module imufp_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  imufp_pkg::frame_cmd_t wr_data,
    input  logic                  pop,
    output imufp_pkg::frame_cmd_t rd_data,
    output imufp_pkg::q_status_t  stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    imufp_pkg::frame_cmd_t entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   level_reg, level_next;

    // pointers wrap after the last entry, so any depth works
    always_comb
    begin
        wr_ptr_next = !push ? wr_ptr_reg :
                      (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = !pop ? rd_ptr_reg :
                      (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        level_next  = level_reg + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
    end

    assign stat.full  = (level_reg == (AW+1)'(DEPTH));
    assign stat.empty = (level_reg == '0);
    assign rd_data    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/imufp_back.sv
module imufp_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    input  imufp_pkg::frame_cmd_t               cmd,
    output logic                                pop,
    input  logic [imufp_pkg::ANGLE_FS_W-1:0]    angle_fs,
    input  logic [imufp_pkg::RATE_FS_W-1:0]     rate_fs,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                frame_kind,
    output logic signed [imufp_pkg::YAW_W-1:0]  yaw_angle,
    output logic signed [imufp_pkg::RATE_W-1:0] rate_y,
    output logic signed [imufp_pkg::RATE_W-1:0] rate_z
);

    localparam int ANGLE_P_W = imufp_pkg::RAW_W + imufp_pkg::ANGLE_FS_W + 1;
    localparam int RATE_P_W  = imufp_pkg::RAW_W + imufp_pkg::RATE_FS_W + 1;

    logic signed [imufp_pkg::RAW_W-1:0] raw_lo, raw_hi;
    logic signed [ANGLE_P_W-1:0] angle_prod;
    logic signed [RATE_P_W-1:0]  rate_y_prod, rate_z_prod;

    logic signed [imufp_pkg::YAW_W-1:0]  held_angle_reg, held_angle_next;
    logic signed [imufp_pkg::RATE_W-1:0] held_ry_reg, held_ry_next;
    logic signed [imufp_pkg::RATE_W-1:0] held_rz_reg, held_rz_next;
    logic out_valid_reg, out_valid_next;
    logic kind_reg;
    logic signed [imufp_pkg::YAW_W-1:0]  yaw_reg;
    logic signed [imufp_pkg::RATE_W-1:0] ry_reg, rz_reg;

    assign pop = cmd_valid && (!out_valid_reg || out_ready);

    assign raw_lo = $signed({cmd.b5, cmd.b4});
    assign raw_hi = $signed({cmd.b7, cmd.b6});

    // products fit the output widths for any register value
    assign angle_prod  = raw_hi * $signed({1'b0, angle_fs});
    assign rate_y_prod = raw_lo * $signed({1'b0, rate_fs});
    assign rate_z_prod = raw_hi * $signed({1'b0, rate_fs});

    always_comb
    begin
        held_angle_next = held_angle_reg;
        held_ry_next    = held_ry_reg;
        held_rz_next    = held_rz_reg;
        if (pop)
        begin
            if (cmd.kind == imufp_pkg::KIND_ANGLE)
            begin
                held_angle_next = angle_prod[imufp_pkg::YAW_W-1:0];
            end
            else
            begin
                held_ry_next = rate_y_prod[imufp_pkg::RATE_W-1:0];
                held_rz_next = rate_z_prod[imufp_pkg::RATE_W-1:0];
            end
        end
        out_valid_next = pop || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_angle_reg <= '0;
            held_ry_reg    <= '0;
            held_rz_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_angle_reg <= held_angle_next;
            held_ry_reg    <= held_ry_next;
            held_rz_reg    <= held_rz_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= cmd.kind;
            yaw_reg  <= held_angle_next;
            ry_reg   <= held_ry_next;
            rz_reg   <= held_rz_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_kind = kind_reg;
    assign yaw_angle  = yaw_reg;
    assign rate_y     = ry_reg;
    assign rate_z     = rz_reg;

endmodule
